// File: hw/rtl/trls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trls_pkg: shared types and constants of the tagged record log store
// Word layouts, store geometry, command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package trls_pkg;

    localparam int STORE_BYTES = 4096;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int PTR_W       = ADDR_W + 1;                    // 0 .. STORE_BYTES
    localparam int LEN_W       = 12;
    localparam int NEED_W      = LEN_W + 1;                     // padded append size
    localparam int RP_W        = $clog2(STORE_BYTES + 8192);    // readout may run past the end
    localparam int SUM_W       = $clog2(STORE_BYTES + 65544);   // cursor plus any header length

    localparam logic [7:0] MAGIC  = 8'hBE;
    localparam logic [7:0] ERASED = 8'hFF;
    localparam int HDR_BYTES  = 4;
    localparam int ALIGN_MASK = 7;

    typedef enum logic [2:0] {
        K_APP_HDR   = 3'd0,
        K_APP_BYTE  = 3'd1,
        K_GET_FIRST = 3'd2,
        K_GET_NEXT  = 3'd3,
        K_READ      = 3'd4,
        K_DISCARD   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_END      = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_NONE     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RES_PLAIN,
        RES_GET,
        RES_READ
    } t_res_sel;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_HDR,
        S_G_CHK,
        S_G_RD,
        S_G_EVAL,
        S_RD_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       record_type;
        logic [LEN_W-1:0] length;
        logic [11:0]      read_offset;
        logic [7:0]       data_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [LEN_W-1:0] copy_count;
        logic [7:0]       read_data;
        logic             last_byte;
    } t_out;

    typedef struct packed {
        logic     load_item;
        logic     clr_start;
        logic     clr_step;
        logic     log_zero;
        logic     hdr_write;
        logic     hdr_commit;
        logic     app_cancel;
        logic     app_write;
        logic     cur_zero;
        logic     rd_disarm;
        logic     get_issue;
        logic     get_step;
        logic     get_eval;
        logic     rd_issue;
        logic     rd_step;
        logic     finish;
        logic     release_res;
        t_status  res_code;
        t_res_sel res_sel;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       too_long;
        logic       no_fit;
        logic       log_empty;
        logic       clr_last;
        logic       idx_zero;
        logic       idx_last;
        logic       app_idle;
        logic       rd_idle;
        logic       cur_at_end;
        logic       magic_bad;
        logic       match;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: hw/rtl/trls_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trls_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module trls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: hw/rtl/trls_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trls_dp: datapath of the tagged record log store
// Byte store, log pointers, header walk arithmetic and result word register.
// ----------------------------------------------------------------------------
module trls_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire trls_pkg::t_in  i_in_data,
    input  wire logic           i_out_stall,
    input  wire trls_pkg::t_cmd i_cmd,
    output trls_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    output trls_pkg::t_out      o_out_data
);
    import trls_pkg::*;

    t_in              r_item;
    logic [PTR_W-1:0] r_log_end, r_cursor, r_app_ptr, r_clr_addr, r_clr_lim;
    logic [LEN_W-1:0] r_app_rem, r_read_rem;
    logic [RP_W-1:0]  r_read_ptr;
    logic [1:0]       r_idx;
    logic [7:0]       r_hb_type, r_hb_lo, r_hb_hi;
    logic             r_rd_oob;
    logic             r_out_valid;
    t_out             r_out_data, r_hold;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    logic [NEED_W-1:0] need;
    logic              too_long, no_fit;
    logic [SUM_W-1:0]  end_sum;
    logic [15:0]       dlen, offs16, avail;
    logic [SUM_W-1:0]  pad_d, cur_sum;
    logic [PTR_W-1:0]  cur_next, hdr_addr, cur_plus;
    logic [LEN_W-1:0]  get_count;
    logic [RP_W-1:0]   rp_start;
    logic              match, out_free;
    logic [7:0]        hdr_byte;
    t_out              res;

    trls_ram #(
        .WIDTH(8),
        .DEPTH(STORE_BYTES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // append sizing
    assign need     = (NEED_W'(r_item.length) + NEED_W'(HDR_BYTES + ALIGN_MASK))
                      & ~NEED_W'(ALIGN_MASK);
    assign too_long = SUM_W'(need) > SUM_W'(STORE_BYTES);
    assign end_sum  = SUM_W'(r_log_end) + SUM_W'(need);
    assign no_fit   = end_sum > SUM_W'(STORE_BYTES);

    // header walk; a cursor past the store saturates, it fails all later gets anyway
    assign dlen     = {r_hb_hi, r_hb_lo};
    assign pad_d    = (SUM_W'(dlen) + SUM_W'(HDR_BYTES + ALIGN_MASK)) & ~SUM_W'(ALIGN_MASK);
    assign cur_sum  = SUM_W'(r_cursor) + pad_d;
    assign cur_next = (cur_sum > SUM_W'(STORE_BYTES)) ? PTR_W'(STORE_BYTES)
                                                      : cur_sum[PTR_W-1:0];
    assign offs16   = 16'(r_item.read_offset);
    assign avail    = (offs16 < dlen) ? (dlen - offs16) : 16'd0;
    assign get_count = (16'(r_item.length) < avail) ? r_item.length : avail[LEN_W-1:0];
    assign rp_start = RP_W'(r_cursor) + RP_W'(HDR_BYTES) + RP_W'(r_item.read_offset);
    assign match    = (r_hb_type == r_item.record_type) || (r_item.record_type == ERASED);

    assign hdr_addr = r_log_end + PTR_W'(r_idx);
    assign cur_plus = r_cursor + PTR_W'(r_idx) + PTR_W'(1);

    always_comb begin
        case (r_idx)
            2'd0:    hdr_byte = MAGIC;
            2'd1:    hdr_byte = r_item.record_type;
            2'd2:    hdr_byte = r_item.length[7:0];
            default: hdr_byte = {4'd0, r_item.length[LEN_W-1:8]};
        endcase
    end

    // store ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr_addr[ADDR_W-1:0];
        ram_wdata = ERASED;
        if (i_cmd.clr_step) begin
            ram_we = 1'b1;
        end else if (i_cmd.hdr_write) begin
            ram_we    = 1'b1;
            ram_waddr = hdr_addr[ADDR_W-1:0];
            ram_wdata = hdr_byte;
        end else if (i_cmd.app_write) begin
            ram_we    = 1'b1;
            ram_waddr = r_app_ptr[ADDR_W-1:0];
            ram_wdata = r_item.data_byte;
        end
        if (i_cmd.get_step) begin
            ram_raddr = cur_plus[ADDR_W-1:0];
        end else if (i_cmd.rd_issue) begin
            ram_raddr = r_read_ptr[ADDR_W-1:0];
        end else begin
            ram_raddr = r_cursor[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_end  <= '0;
            r_cursor   <= '0;
            r_app_ptr  <= '0;
            r_app_rem  <= '0;
            r_read_ptr <= '0;
            r_read_rem <= '0;
            r_clr_addr <= '0;
            r_clr_lim  <= PTR_W'(STORE_BYTES);
            r_idx      <= '0;
        end else begin
            if (i_cmd.clr_start) begin
                r_clr_addr <= '0;
                r_clr_lim  <= r_log_end;
            end else if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + PTR_W'(1);
            end

            if (i_cmd.load_item || i_cmd.get_issue) begin
                r_idx <= '0;
            end else if (i_cmd.hdr_write || i_cmd.get_step) begin
                r_idx <= r_idx + 2'd1;
            end

            if (i_cmd.log_zero) begin
                r_log_end <= '0;
            end else if (i_cmd.hdr_commit) begin
                r_log_end <= end_sum[PTR_W-1:0];
            end

            if (i_cmd.hdr_commit) begin
                r_app_ptr <= r_log_end + PTR_W'(HDR_BYTES);
            end else if (i_cmd.app_write) begin
                r_app_ptr <= r_app_ptr + PTR_W'(1);
            end

            if (i_cmd.app_cancel) begin
                r_app_rem <= '0;
            end else if (i_cmd.hdr_commit) begin
                r_app_rem <= r_item.length;
            end else if (i_cmd.app_write) begin
                r_app_rem <= r_app_rem - LEN_W'(1);
            end

            if (i_cmd.cur_zero) begin
                r_cursor <= '0;
            end else if (i_cmd.get_eval) begin
                r_cursor <= cur_next;
            end

            if (i_cmd.rd_disarm) begin
                r_read_rem <= '0;
            end else if (i_cmd.get_eval && match) begin
                r_read_rem <= get_count;
                r_read_ptr <= rp_start;
            end else if (i_cmd.rd_step) begin
                r_read_rem <= r_read_rem - LEN_W'(1);
                r_read_ptr <= r_read_ptr + RP_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.get_step) begin
            case (r_idx)
                2'd1:    r_hb_type <= ram_rdata;
                2'd2:    r_hb_lo   <= ram_rdata;
                2'd3:    r_hb_hi   <= ram_rdata;
                default: ;
            endcase
        end
        if (i_cmd.rd_issue) begin
            r_rd_oob <= r_read_ptr >= RP_W'(STORE_BYTES);
        end
    end

    // result word
    always_comb begin
        res.status     = i_cmd.res_code;
        res.copy_count = (i_cmd.res_sel == RES_GET) ? get_count : '0;
        res.read_data  = '0;
        res.last_byte  = 1'b0;
        if (i_cmd.res_sel == RES_READ) begin
            res.read_data = r_rd_oob ? ERASED : ram_rdata;
            res.last_byte = (r_read_rem == LEN_W'(1));
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.finish && out_free) || i_cmd.release_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && out_free) begin
            r_out_data <= res;
        end else if (i_cmd.release_res) begin
            r_out_data <= r_hold;
        end
        if (i_cmd.finish && !out_free) begin
            r_hold <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        o_sts.kind       = r_item.kind;
        o_sts.too_long   = too_long;
        o_sts.no_fit     = no_fit;
        o_sts.log_empty  = (r_log_end == '0);
        o_sts.clr_last   = ((r_clr_addr + PTR_W'(1)) == r_clr_lim);
        o_sts.idx_zero   = (r_idx == 2'd0);
        o_sts.idx_last   = (r_idx == 2'd3);
        o_sts.app_idle   = (r_app_rem == '0);
        o_sts.rd_idle    = (r_read_rem == '0);
        o_sts.cur_at_end = (r_cursor >= r_log_end);
        o_sts.magic_bad  = (ram_rdata != MAGIC);
        o_sts.match      = match;
        o_sts.out_free   = out_free;
    end

endmodule
`default_nettype wire

// File: hw/rtl/trls_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trls_ctrl: sequencer of the tagged record log store
// Decodes each word, walks clears, header writes and record searches.
// ----------------------------------------------------------------------------
module trls_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire trls_pkg::t_sts i_sts,
    output trls_pkg::t_cmd      o_cmd
);
    import trls_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.res_code = ST_OK;
        o_cmd.res_sel  = RES_PLAIN;
        o_in_stall    = (r_state != S_IDLE);

        unique case (r_state)
            S_INIT: begin
                // post-reset erase of the whole store
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.kind)
                    K_APP_HDR: begin
                        if (i_sts.too_long) begin
                            o_cmd.app_cancel = 1'b1;
                            o_cmd.finish     = 1'b1;
                            o_cmd.res_code   = ST_TOO_LONG;
                            n_state = i_sts.out_free ? S_IDLE : S_DONE;
                        end else if (i_sts.no_fit) begin
                            o_cmd.clr_start = 1'b1;
                            n_state = S_CLEAR;
                        end else begin
                            n_state = S_HDR;
                        end
                    end
                    K_APP_BYTE: begin
                        o_cmd.finish = 1'b1;
                        if (i_sts.app_idle) begin
                            o_cmd.res_code = ST_NONE;
                        end else begin
                            o_cmd.app_write = 1'b1;
                        end
                        n_state = i_sts.out_free ? S_IDLE : S_DONE;
                    end
                    K_GET_FIRST: begin
                        o_cmd.cur_zero  = 1'b1;
                        o_cmd.rd_disarm = 1'b1;
                        n_state = S_G_CHK;
                    end
                    K_GET_NEXT: begin
                        o_cmd.rd_disarm = 1'b1;
                        n_state = S_G_CHK;
                    end
                    K_READ: begin
                        if (i_sts.rd_idle) begin
                            o_cmd.finish   = 1'b1;
                            o_cmd.res_code = ST_NONE;
                            n_state = i_sts.out_free ? S_IDLE : S_DONE;
                        end else begin
                            o_cmd.rd_issue = 1'b1;
                            n_state = S_RD_WAIT;
                        end
                    end
                    K_DISCARD: begin
                        o_cmd.cur_zero   = 1'b1;
                        o_cmd.app_cancel = 1'b1;
                        o_cmd.rd_disarm  = 1'b1;
                        if (i_sts.log_empty) begin
                            o_cmd.finish = 1'b1;
                            n_state = i_sts.out_free ? S_IDLE : S_DONE;
                        end else begin
                            o_cmd.clr_start = 1'b1;
                            n_state = S_CLEAR;
                        end
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                        n_state = i_sts.out_free ? S_IDLE : S_DONE;
                    end
                endcase
            end
            S_CLEAR: begin
                // erase only the used part; past log_end the store is already erased
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.log_zero = 1'b1;
                    if (i_sts.kind == K_APP_HDR) begin
                        n_state = S_HDR;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state = i_sts.out_free ? S_IDLE : S_DONE;
                    end
                end
            end
            S_HDR: begin
                o_cmd.hdr_write = 1'b1;
                if (i_sts.idx_last) begin
                    o_cmd.hdr_commit = 1'b1;
                    o_cmd.finish     = 1'b1;
                    n_state = i_sts.out_free ? S_IDLE : S_DONE;
                end
            end
            S_G_CHK: begin
                if (i_sts.cur_at_end) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.res_code = ST_END;
                    n_state = i_sts.out_free ? S_IDLE : S_DONE;
                end else begin
                    o_cmd.get_issue = 1'b1;
                    n_state = S_G_RD;
                end
            end
            S_G_RD: begin
                o_cmd.get_step = 1'b1;
                if (i_sts.idx_zero && i_sts.magic_bad) begin
                    // broken header: cursor stays put
                    o_cmd.finish   = 1'b1;
                    o_cmd.res_code = ST_END;
                    n_state = i_sts.out_free ? S_IDLE : S_DONE;
                end else if (i_sts.idx_last) begin
                    n_state = S_G_EVAL;
                end
            end
            S_G_EVAL: begin
                o_cmd.get_eval = 1'b1;
                if (i_sts.match) begin
                    o_cmd.finish  = 1'b1;
                    o_cmd.res_sel = RES_GET;
                    n_state = i_sts.out_free ? S_IDLE : S_DONE;
                end else begin
                    n_state = S_G_CHK;
                end
            end
            S_RD_WAIT: begin
                o_cmd.rd_step = 1'b1;
                o_cmd.finish  = 1'b1;
                o_cmd.res_sel = RES_READ;
                n_state = i_sts.out_free ? S_IDLE : S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.release_res = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/tagged_record_log_store_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word at a time; the sequencer stalls the input until the word in work is done.
//   Append headers that do not fit and discards first erase the used part of the store;
//   a get reads the headers record by record until a match, a bad magic or the end of the log.
// Result: loaded at the edge ending the last step; a stalled result holds the input.
// Reset: synchronous, active low; afterwards an erase pass fills the whole
//   store with 0xFF while the input side stalls.
// ----------------------------------------------------------------------------
// tagged_record_log_store_top: append-only store of tagged, padded records
// Sequencer plus datapath around one byte-wide store.
// ----------------------------------------------------------------------------
module tagged_record_log_store_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire trls_pkg::t_in i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output trls_pkg::t_out     o_out_data,
    input  wire logic          i_out_stall
);
    import trls_pkg::*;

    t_cmd cmd;
    t_sts sts;

    trls_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    trls_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_out_stall(i_out_stall),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );

endmodule
`default_nettype wire

// File: tb/sv/tagged_record_log_store_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_record_log_store_top_test: self-checking bench for the record log store
// Appends, searches, readouts and discards are sent in bursts while the result
// side stalls at random. A behavioral mirror of the store predicts every result
// word, and the results are checked in arrival order.
// ----------------------------------------------------------------------------
module tagged_record_log_store_top_test;
    import trls_pkg::*;

    localparam int ERR_SHOW   = 10;
    localparam int RAND_WORDS = 1750;
    localparam logic [2:0] K_SPARE_LO = 3'd6;
    localparam logic [2:0] K_SPARE_HI = 3'd7;

    typedef enum {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_LIGHT
    } t_stall_mode;

    typedef struct {
        t_in word;
        bit  hold;
    } t_pend;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    t_pend send_q[$];
    t_out  result_q[$];
    int    err_cnt = 0;
    bit    in_fire = 1'b0;
    bit    hold_pending = 1'b0;
    int    gen_cnt = 0;
    int    gap_left = 0;
    int    burst_left = 1;
    int    stall_left = 0;
    t_stall_mode stall_mode = STALL_NONE;

    // mirror of the store and its pointers
    logic [7:0]  mir_mem [0:STORE_BYTES-1];
    int unsigned mir_end, mir_cursor, mir_app_ptr, mir_app_left, mir_rd_ptr, mir_rd_left;

    tagged_record_log_store_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always #2 i_clk = ~i_clk;

    function automatic int unsigned rec_span(int unsigned dlen);
        return (HDR_BYTES + dlen + ALIGN_MASK) & ~32'(ALIGN_MASK);
    endfunction

    function automatic void mir_clear();
        foreach (mir_mem[i]) mir_mem[i] = ERASED;
        mir_end = 0;
    endfunction

    function automatic logic [7:0] mir_peek(int unsigned a);
        return (a < STORE_BYTES) ? mir_mem[a] : ERASED;
    endfunction

    function automatic void mir_poke(int unsigned a, logic [7:0] v);
        if (a < STORE_BYTES) mir_mem[a] = v;
    endfunction

    function automatic t_out log_predict(t_in w);
        t_out        res;
        int unsigned need, c, dlen, avail;
        bit          found, stop;
        res = '0;
        res.status = ST_OK;
        found = 1'b0;
        stop = 1'b0;
        case (w.kind)
            K_APP_HDR: begin
                need = rec_span(32'(w.length));
                if (need > STORE_BYTES) begin
                    res.status = ST_TOO_LONG;
                    mir_app_left = 0;
                end else begin
                    // no room left: wipe and start over at 0
                    if (mir_end + need > STORE_BYTES) mir_clear();
                    mir_poke(mir_end, MAGIC);
                    mir_poke(mir_end + 1, w.record_type);
                    mir_poke(mir_end + 2, w.length[7:0]);
                    mir_poke(mir_end + 3, {4'h0, w.length[11:8]});
                    mir_app_ptr = mir_end + HDR_BYTES;
                    mir_app_left = 32'(w.length);
                    mir_end += need;
                end
            end
            K_APP_BYTE: begin
                if (mir_app_left == 0) begin
                    res.status = ST_NONE;
                end else begin
                    mir_poke(mir_app_ptr, w.data_byte);
                    mir_app_ptr++;
                    mir_app_left--;
                end
            end
            K_GET_FIRST, K_GET_NEXT: begin
                if (w.kind == K_GET_FIRST) mir_cursor = 0;
                mir_rd_left = 0;
                while (!found && !stop && mir_cursor < mir_end) begin
                    c = mir_cursor;
                    if (mir_peek(c) != MAGIC) begin
                        stop = 1'b1;    // cursor stays on the bad header
                    end else begin
                        dlen = 32'({mir_peek(c + 3), mir_peek(c + 2)});
                        mir_cursor = c + rec_span(dlen);
                        if (mir_peek(c + 1) == w.record_type || w.record_type == ERASED) begin
                            avail = (32'(w.read_offset) < dlen) ?
                                    dlen - 32'(w.read_offset) : 0;
                            res.copy_count = 12'((32'(w.length) < avail) ?
                                                 32'(w.length) : avail);
                            mir_rd_ptr = c + HDR_BYTES + 32'(w.read_offset);
                            mir_rd_left = 32'(res.copy_count);
                            found = 1'b1;
                        end
                    end
                end
                if (!found) res.status = ST_END;
            end
            K_READ: begin
                if (mir_rd_left == 0) begin
                    res.status = ST_NONE;
                end else begin
                    res.read_data = mir_peek(mir_rd_ptr);
                    mir_rd_ptr++;
                    mir_rd_left--;
                    res.last_byte = (mir_rd_left == 0);
                end
            end
            K_DISCARD: begin
                mir_clear();
                mir_cursor = 0;
                mir_app_left = 0;
                mir_rd_left = 0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic logic [7:0] pick_tag();
        logic [7:0] tags [4];
        tags = '{8'h00, 8'h5A, 8'hC3, 8'hA5};
        return ($urandom_range(0, 3) == 0) ? 8'($urandom) : tags[$urandom_range(0, 3)];
    endfunction

    task automatic queue_word(input logic [2:0] k, input logic [7:0] rt,
                              input logic [11:0] len, input logic [11:0] offs);
        t_pend p;
        p.word.kind = k;
        p.word.record_type = rt;
        p.word.length = len;
        p.word.read_offset = offs;
        // magic value in the data now and then, so stale cursors can land on it
        p.word.data_byte = ($urandom_range(0, 15) == 0) ? MAGIC : 8'($urandom);
        p.hold = hold_pending;
        hold_pending = 1'b0;
        send_q.push_back(p);
        if (k <= K_DISCARD) gen_cnt++;
    endtask

    task automatic add_plain(input logic [2:0] k, input int n);
        repeat (n) queue_word(k, 8'($urandom), 12'($urandom), 12'($urandom));
    endtask

    // sender: bursts of words with random gaps
    always @(negedge i_clk) begin
        logic nxt_valid;
        t_in  nxt_word;
        nxt_valid = i_in_valid;
        nxt_word = i_in_data;
        if (i_rst_n && !(i_in_valid && !in_fire)) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (send_q.size() > 0 && !(send_q[0].hold && result_q.size() > 0)) begin
                nxt_valid = 1'b1;
                nxt_word = send_q[0].word;
                send_q.delete(0);
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 24);
                    gap_left = $urandom_range(1, 8);
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data <= nxt_word;
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_HALF:  i_out_stall <= 1'($urandom_range(0, 1));
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // monitor: check results first, then predict the word taken at this edge
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= ERR_SHOW)
                        $display("%0t: result word with nothing pending:", $time,
                                 " st=%0d cnt=%0d", o_out_data.status,
                                 o_out_data.copy_count,
                                 " data=%02h last=%0d", o_out_data.read_data,
                                 o_out_data.last_byte);
                end else begin
                    want = result_q.pop_front();
                    if (o_out_data.status !== want.status ||
                        o_out_data.copy_count !== want.copy_count ||
                        o_out_data.read_data !== want.read_data ||
                        o_out_data.last_byte !== want.last_byte) begin
                        err_cnt++;
                        if (err_cnt <= ERR_SHOW)
                            $display("%0t: want st=%0d cnt=%0d data=%02h last=%0d,", $time,
                                     want.status, want.copy_count, want.read_data,
                                     want.last_byte,
                                     " got st=%0d cnt=%0d data=%02h last=%0d",
                                     o_out_data.status, o_out_data.copy_count,
                                     o_out_data.read_data, o_out_data.last_byte);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) result_q.push_back(log_predict(i_in_data));
            in_fire <= i_in_valid && !o_in_stall;
        end
    end

    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int          pick, sel, len, nb;
        logic [2:0]  k;
        logic [7:0]  rt;
        logic [11:0] offs;
        int          next_hold;

        mir_clear();
        mir_cursor = 0;
        mir_app_ptr = 0;
        mir_app_left = 0;
        mir_rd_ptr = 0;
        mir_rd_left = 0;

        // directed opening
        queue_word(K_APP_HDR, 8'h00, 12'd0, 12'd0);
        queue_word(K_APP_HDR, 8'h5A, 12'd3, 12'hFFF);
        add_plain(K_APP_BYTE, 4);                           // last byte has no append open
        queue_word(K_APP_HDR, 8'hC3, 12'd5, 12'd0);
        add_plain(K_APP_BYTE, 2);
        queue_word(K_APP_HDR, 8'h11, 12'd1, 12'd0);         // takes over the unfinished record
        add_plain(K_APP_BYTE, 1);
        queue_word(K_GET_FIRST, ERASED, 12'hFFF, 12'd0);    // empty record, zero bytes
        add_plain(K_READ, 1);
        queue_word(K_GET_NEXT, 8'h5A, 12'd2, 12'd1);
        add_plain(K_READ, 3);
        queue_word(K_GET_NEXT, 8'hC3, 12'hFFF, 12'd0);
        add_plain(K_READ, 2);
        queue_word(K_GET_NEXT, 8'h11, 12'hFFF, 12'hFFF);
        queue_word(K_GET_NEXT, ERASED, 12'd4, 12'd0);       // end of log
        queue_word(K_APP_HDR, 8'hFF, 12'd4093, 12'd0);      // too long
        add_plain(K_APP_BYTE, 1);
        queue_word(K_APP_HDR, 8'h77, 12'hFFF, 12'd0);
        queue_word(K_SPARE_LO, 8'hFF, 12'hFFF, 12'hFFF);
        queue_word(K_SPARE_HI, 8'h00, 12'd0, 12'd0);
        add_plain(K_DISCARD, 1);
        queue_word(K_GET_FIRST, ERASED, 12'd8, 12'd0);
        add_plain(K_READ, 1);
        queue_word(K_APP_HDR, 8'h3C, 12'd4092, 12'd0);      // fills the store exactly
        queue_word(K_APP_HDR, 8'h00, 12'd0, 12'd0);         // no room: store wiped
        queue_word(K_GET_NEXT, ERASED, 12'd1, 12'd0);

        // random part: mostly complete append and get sequences
        gen_cnt = 0;
        hold_pending = 1'b1;
        next_hold = 250;
        while (gen_cnt < RAND_WORDS) begin
            if (gen_cnt >= next_hold) begin
                hold_pending = 1'b1;
                next_hold += 250 + $urandom_range(0, 200);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                sel = $urandom_range(0, 99);
                if (sel < 80)      len = $urandom_range(0, 24);
                else if (sel < 92) len = $urandom_range(25, 600);
                else if (sel < 97) len = $urandom_range(601, 4092);
                else               len = $urandom_range(4093, 4095);
                queue_word(K_APP_HDR, pick_tag(), 12'(len), 12'($urandom));
                if (len > 40) begin
                    nb = $urandom_range(0, 8);
                end else begin
                    sel = $urandom_range(0, 9);
                    nb = (sel == 0) ? $urandom_range(0, len) : (sel == 1) ? len + 1 : len;
                end
                add_plain(K_APP_BYTE, nb);
            end else if (pick < 75) begin
                k = ($urandom_range(0, 3) == 0) ? K_GET_FIRST : K_GET_NEXT;
                rt = ($urandom_range(0, 2) == 0) ? ERASED : pick_tag();
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 32);
                offs = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 8));
                queue_word(k, rt, 12'(len), offs);
                add_plain(K_READ, $urandom_range(0, ((len < 40) ? len : 40) + 1));
            end else if (pick < 85) begin
                add_plain(K_READ, $urandom_range(1, 3));
            end else if (pick < 90) begin
                add_plain(K_DISCARD, 1);
            end else if (pick < 95) begin
                add_plain(K_APP_BYTE, $urandom_range(1, 2));
            end else begin
                add_plain(($urandom_range(0, 1) == 0) ? K_SPARE_LO : K_SPARE_HI, 1);
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (send_q.size() > 0 || i_in_valid || result_q.size() > 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/trls_pkg.sv
hw/rtl/trls_ram.sv
hw/rtl/trls_dp.sv
hw/rtl/trls_ctrl.sv
hw/rtl/tagged_record_log_store_top.sv
tb/sv/tagged_record_log_store_top_test.sv
